// ===== rtl/aob_pkg.sv =====
package aob_pkg;

  localparam int SCREEN_WIDTH   = 640;
  localparam int VISIBLE_ROWS   = 330;
  localparam int MAX_SPRITE_DIM = 1024;
  localparam int FULL_ALPHA     = 250;

  localparam int PX_W  = $clog2(SCREEN_WIDTH);
  localparam int PY_W  = $clog2(VISIBLE_ROWS);
  localparam int LIN_W = $clog2(SCREEN_WIDTH * VISIBLE_ROWS);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_BASE    = 3'd0,
    REG_ORIGIN_X      = 3'd1,
    REG_ORIGIN_Y      = 3'd2,
    REG_SPRITE_WIDTH  = 3'd3,
    REG_SPRITE_HEIGHT = 3'd4,
    REG_GLOBAL_ALPHA  = 3'd5
  } cfg_reg_t;

  // stage advance strobes for the channel blender
  typedef struct packed {
    logic en_a;
    logic en_b;
  } mix_ctl_t;

endpackage

// ===== rtl/aob_if.sv =====
interface aob_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  sprite_col;
  logic [9:0]  sprite_row;
  logic [15:0] src_pixel;
  logic [15:0] dst_pixel;

  modport source (output valid, sprite_col, sprite_row, src_pixel, dst_pixel, input ready);
  modport sink   (input valid, sprite_col, sprite_row, src_pixel, dst_pixel, output ready);
endinterface

interface aob_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [31:0] write_address;
  logic [15:0] write_color;

  modport source (output valid, write_enable, write_address, write_color, input ready);
  modport sink   (input valid, write_enable, write_address, write_color, output ready);
endinterface

// ===== rtl/aob_mix.sv =====
// One color channel: dst + floor((src - dst) * eff / 256), two register stages.
module aob_mix (
  input  logic            clk,
  input  aob_pkg::mix_ctl_t ctl,
  input  logic [5:0]      src,
  input  logic [5:0]      dst,
  input  logic [7:0]      eff,
  input  logic            full,
  input  logic            wr,
  output logic [5:0]      res
);

  logic signed [6:0]  diff;
  logic signed [15:0] prod_nxt, prod_r;
  logic [5:0]         src_r, dst_r;
  logic               full_r, wr_r;
  logic signed [7:0]  q;
  logic [5:0]         res_nxt, res_r;

  assign diff     = $signed({1'b0, src}) - $signed({1'b0, dst});
  assign prod_nxt = 16'(diff * $signed({1'b0, eff}));

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      prod_r <= prod_nxt;
      src_r  <= src;
      dst_r  <= dst;
      full_r <= full;
      wr_r   <= wr;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign q = prod_r[15:8];

  always_comb begin
    if (!wr_r) begin
      res_nxt = '0;
    end else if (full_r) begin
      res_nxt = src_r;
    end else begin
      res_nxt = dst_r + q[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/argb4444_over_rgb565_blend.sv =====
// Throughput: one pixel per clock while out_ch.ready does not stall it; four register stages (clip,
// alpha multiply, channel multiply plus address add, output) each with its own valid bit.
// Reset (synchronous, rst_n low): pipeline emptied, all configuration registers
// cleared to zero, which disables all writes until global alpha and sprite size are set.
module argb4444_over_rgb565_blend (
  input  logic                           clk,
  input  logic                           rst_n,
  aob_in_if.sink                         in_ch,
  aob_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [aob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aob_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PX_W  = aob_pkg::PX_W;
  localparam int PY_W  = aob_pkg::PY_W;
  localparam int LIN_W = aob_pkg::LIN_W;

  // configuration
  logic [31:0] frame_base_r;
  logic [11:0] origin_x_r, origin_y_r;
  logic [10:0] sprite_width_r, sprite_height_r;
  logic [7:0]  global_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r    <= '0;
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      sprite_width_r  <= '0;
      sprite_height_r <= '0;
      global_alpha_r  <= '0;
    end else if (cfg_we) begin
      unique case (aob_pkg::cfg_reg_t'(cfg_index))
        aob_pkg::REG_FRAME_BASE:    frame_base_r    <= cfg_wdata;
        aob_pkg::REG_ORIGIN_X:      origin_x_r      <= cfg_wdata[11:0];
        aob_pkg::REG_ORIGIN_Y:      origin_y_r      <= cfg_wdata[11:0];
        aob_pkg::REG_SPRITE_WIDTH:  sprite_width_r  <= cfg_wdata[10:0];
        aob_pkg::REG_SPRITE_HEIGHT: sprite_height_r <= cfg_wdata[10:0];
        aob_pkg::REG_GLOBAL_ALPHA:  global_alpha_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: placement and clipping
  logic signed [12:0] px, py;
  logic [12:0]        col_ext, row_ext;
  logic               in_sprite, on_screen, ok1_nxt;
  logic [3:0]         a4, r4, g4, b4;

  assign col_ext = {3'b0, in_ch.sprite_col};
  assign row_ext = {3'b0, in_ch.sprite_row};
  assign px = $signed({origin_x_r[11], origin_x_r}) + $signed(col_ext);
  assign py = $signed({origin_y_r[11], origin_y_r}) + $signed(row_ext);
  assign a4 = in_ch.src_pixel[15:12];
  assign r4 = in_ch.src_pixel[11:8];
  assign g4 = in_ch.src_pixel[7:4];
  assign b4 = in_ch.src_pixel[3:0];

  assign in_sprite = (col_ext < {2'b0, sprite_width_r})
                  && (col_ext < 13'(aob_pkg::MAX_SPRITE_DIM))
                  && (row_ext < {2'b0, sprite_height_r})
                  && (row_ext < 13'(aob_pkg::MAX_SPRITE_DIM));
  assign on_screen = !px[12] && (px < 13'(aob_pkg::SCREEN_WIDTH))
                  && !py[12] && (py < 13'(aob_pkg::VISIBLE_ROWS));
  assign ok1_nxt = (global_alpha_r != 8'd0) && in_sprite && on_screen && (a4 != 4'd0);

  logic            ok1_r;
  logic [PX_W-1:0] px1_r;
  logic [PY_W-1:0] py1_r;
  logic [7:0]      a17_r;
  logic [4:0]      rs1_r, bs1_r;
  logic [5:0]      gs1_r;
  logic [15:0]     dst1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      ok1_r  <= ok1_nxt;
      px1_r  <= px[PX_W-1:0];
      py1_r  <= py[PY_W-1:0];
      a17_r  <= {a4, a4};
      rs1_r  <= {r4, r4[3]};
      gs1_r  <= {g4, g4[3:2]};
      bs1_r  <= {b4, b4[3]};
      dst1_r <= in_ch.dst_pixel;
    end
  end

  // stage 2: effective alpha and linear pixel index
  logic [15:0]      alpha_prod;
  logic [LIN_W-1:0] lin_nxt;

  assign alpha_prod = a17_r * global_alpha_r;
  assign lin_nxt = LIN_W'(py1_r) * LIN_W'(aob_pkg::SCREEN_WIDTH) + LIN_W'(px1_r);

  logic             ok2_r;
  logic [7:0]       eff2_r;
  logic [LIN_W-1:0] lin2_r;
  logic [4:0]       rs2_r, bs2_r;
  logic [5:0]       gs2_r;
  logic [15:0]      dst2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      ok2_r  <= ok1_r && (alpha_prod[15:8] != 8'd0);
      eff2_r <= alpha_prod[15:8];
      lin2_r <= lin_nxt;
      rs2_r  <= rs1_r;
      gs2_r  <= gs1_r;
      bs2_r  <= bs1_r;
      dst2_r <= dst1_r;
    end
  end

  // stage 3: byte address; channel products run inside the blenders
  logic             full2;
  logic             ok3_r;
  logic [31:0]      addr3_r;
  aob_pkg::mix_ctl_t mix_ctl;
  logic [5:0]       r_res, g_res, b_res;

  assign full2 = eff2_r >= 8'(aob_pkg::FULL_ALPHA);
  assign mix_ctl.en_a = en3;
  assign mix_ctl.en_b = en4;

  always_ff @(posedge clk) begin
    if (en3) begin
      ok3_r   <= ok2_r;
      addr3_r <= frame_base_r + 32'({lin2_r, 1'b0});
    end
  end

  aob_mix u_mix_r (
    .clk (clk), .ctl (mix_ctl), .src ({1'b0, rs2_r}), .dst ({1'b0, dst2_r[15:11]}),
    .eff (eff2_r), .full (full2), .wr (ok2_r), .res (r_res)
  );

  aob_mix u_mix_g (
    .clk (clk), .ctl (mix_ctl), .src (gs2_r), .dst (dst2_r[10:5]),
    .eff (eff2_r), .full (full2), .wr (ok2_r), .res (g_res)
  );

  aob_mix u_mix_b (
    .clk (clk), .ctl (mix_ctl), .src ({1'b0, bs2_r}), .dst ({1'b0, dst2_r[4:0]}),
    .eff (eff2_r), .full (full2), .wr (ok2_r), .res (b_res)
  );

  // stage 4: output register
  logic        ok4_r;
  logic [31:0] addr4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      ok4_r   <= ok3_r;
      addr4_r <= ok3_r ? addr3_r : 32'd0;
    end
  end

  assign out_ch.valid         = v4_r;
  assign out_ch.write_enable  = ok4_r;
  assign out_ch.write_address = addr4_r;
  assign out_ch.write_color   = {r_res[4:0], g_res, b_res[4:0]};

endmodule

// ===== rtl/aob_chk.sv =====
module aob_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_enable,
  input logic [31:0] out_write_address,
  input logic [15:0] out_write_color
);

  // a beat with no write carries zero address and color
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_write_address == 32'd0 && out_write_color == 16'd0))
    else $error("no-write beat with nonzero payload");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // an accepted pixel later keeps the output side busy
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##4 out_valid)
    else $error("accepted pixel did not reach the output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_write_enable)
      && $stable(out_write_address) && $stable(out_write_color)))
    else $error("stalled result changed");

endmodule

bind argb4444_over_rgb565_blend aob_chk u_aob_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_write_enable  (out_ch.write_enable),
  .out_write_address (out_ch.write_address),
  .out_write_color   (out_ch.write_color)
);
